@@ rtl/small_range_index_of_table_defines.svh @@
// Assertion macros shared by the index-of engine RTL.
`ifndef SMALL_RANGE_INDEX_OF_TABLE_DEFINES_SVH
`define SMALL_RANGE_INDEX_OF_TABLE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SIDX_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sidx assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SIDX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sidx assertion failed");

`endif

@@ rtl/sidx_pkg.sv @@
// Package with shared constants, types and helpers of the index-of engine.
`timescale 1ns / 1ps

package sidx_pkg;

    localparam int TABLE_DEPTH    = 4096;
    localparam int POSITION_WIDTH = 16;
    localparam int IDX_W          = $clog2(TABLE_DEPTH);
    localparam int SPAN_W         = $clog2(TABLE_DEPTH + 1);
    localparam int GEN_W          = 8;
    localparam int MEM_W          = GEN_W + POSITION_WIDTH;
    localparam int CFG_ADDR_W     = 5;
    localparam int CFG_DATA_W     = 64;

    localparam logic [1:0] REG_RANGE_MIN  = 2'd0;
    localparam logic [1:0] REG_RANGE_SIZE = 2'd1;
    localparam logic [1:0] REG_KEEP_LAST  = 2'd2;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_SELF  = 2'd3
    } mode_t;

    typedef struct packed {
        logic signed [63:0] range_min;
        logic [12:0]        range_size;
        logic               keep_last;
    } cfg_t;

    function automatic logic [15:0] pos_to_out(input logic [POSITION_WIDTH-1:0] p);
        logic [31:0] w;
        w = 32'(p);
        return w[15:0];
    endfunction

endpackage

@@ rtl/sidx_cfg.sv @@
// APB-style configuration register file of the index-of engine.
`timescale 1ns / 1ps

module sidx_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sidx_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [sidx_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [sidx_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready,
    output sidx_pkg::cfg_t                     cfg
);
    import sidx_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[4:3];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_RANGE_MIN:  cfg_next.range_min  = $signed(pwdata);
                REG_RANGE_SIZE: cfg_next.range_size = pwdata[12:0];
                REG_KEEP_LAST:  cfg_next.keep_last  = pwdata[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_RANGE_MIN:  prdata = cfg_reg.range_min;
            REG_RANGE_SIZE: prdata = 64'(cfg_reg.range_size);
            REG_KEEP_LAST:  prdata = 64'(cfg_reg.keep_last);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_min  <= '0;
            cfg_reg.range_size <= 13'd4096;
            cfg_reg.keep_last  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/small_range_index_of_table.sv @@
// Top level of the small-range index-of engine with its directly addressed table.
//
//  channel | direction | handshake               | beat contents
//  --------+-----------+-------------------------+--------------------------------
//  in      | in        | in_valid / in_stall     | mode, value
//  out     | out       | out_valid / out_stall   | position, found, first_seen
//  cfg     | in        | psel, penable, pready   | paddr, pwdata, prdata
//
// Each item has three steps: accept and index, table read, then update and result.
// A new item is accepted only once the previous one has left the update step.
// After reset, and after every clear that wraps the generation tag, a clearing
// pass over all TABLE_DEPTH (4096) entries sweeps the table; in_stall stays high.
// A result waits in the output register; a further result item holds in its last
// cycle until that register is free.
`timescale 1ns / 1ps
`include "small_range_index_of_table_defines.svh"

module small_range_index_of_table (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sidx_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [sidx_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [sidx_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         mode,
    input  logic signed [63:0]                 value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [15:0]                        position,
    output logic                               found,
    output logic                               first_seen
);
    import sidx_pkg::*;

    typedef enum logic [3:0] {
        S_SWEEP = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_EXEC  = 4'b1000
    } state_t;

    cfg_t                       cfg;
    state_t                     state_reg;
    state_t                     state_next;
    logic [GEN_W-1:0]           gen_reg;
    logic [GEN_W-1:0]           gen_next;
    logic [POSITION_WIDTH-1:0]  pos_reg;
    logic [POSITION_WIDTH-1:0]  pos_next;
    logic [IDX_W-1:0]           sweep_reg;
    logic [IDX_W-1:0]           sweep_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;

    mode_t                      mode_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic                       inr_reg;
    logic [15:0]                position_reg;
    logic                       found_reg;
    logic                       first_seen_reg;

    logic [MEM_W-1:0]           mem [TABLE_DEPTH];
    logic [MEM_W-1:0]           rdata_reg;
    logic                       mem_we;
    logic [IDX_W-1:0]           mem_waddr;
    logic [MEM_W-1:0]           mem_wdata;
    logic                       mem_re;

    logic                       in_accept;
    logic [63:0]                offset;
    logic                       below;
    logic [SPAN_W-1:0]          span;
    logic                       in_range;
    logic [GEN_W-1:0]           rd_tag;
    logic [POSITION_WIDTH-1:0]  rd_pos;
    logic                       present;
    logic                       has_result;
    logic                       proceed;
    logic                       do_store;
    logic                       do_bump;
    logic [POSITION_WIDTH-1:0]  res_pos;

    sidx_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign offset   = value - cfg.range_min;
    assign below    = value < cfg.range_min;
    assign span     = (32'(cfg.range_size) < 32'(TABLE_DEPTH)) ? SPAN_W'(cfg.range_size)
                                                              : SPAN_W'(TABLE_DEPTH);
    assign in_range = !below && (offset < 64'(span));

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg <= mode_t'(mode);
            idx_reg  <= offset[IDX_W-1:0];
            inr_reg  <= in_range;
        end
    end

    assign rd_tag  = rdata_reg[MEM_W-1 -: GEN_W];
    assign rd_pos  = rdata_reg[POSITION_WIDTH-1:0];
    assign present = inr_reg && (rd_tag == gen_reg);

    assign has_result = (mode_reg == MODE_QUERY) || (mode_reg == MODE_SELF);
    assign proceed    = !has_result || !out_valid_reg || !out_stall;

    always_comb
    begin
        do_store = 1'b0;
        do_bump  = 1'b0;
        case (mode_reg)
            MODE_LOAD:
            begin
                do_store = inr_reg && (!present || cfg.keep_last);
                do_bump  = 1'b1;
            end
            MODE_SELF:
            begin
                do_store = inr_reg && !present;
                do_bump  = 1'b1;
            end
            default:
            begin
                do_store = 1'b0;
                do_bump  = 1'b0;
            end
        endcase
    end

    assign res_pos = present ? rd_pos : pos_reg;

    assign mem_re    = (state_reg == S_READ);
    assign mem_we    = (state_reg == S_SWEEP) || ((state_reg == S_EXEC) && proceed && do_store);
    assign mem_waddr = (state_reg == S_SWEEP) ? sweep_reg : idx_reg;
    assign mem_wdata = (state_reg == S_SWEEP) ? '0 : {gen_reg, pos_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[idx_reg];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        gen_next       = gen_reg;
        pos_next       = pos_reg;
        sweep_next     = sweep_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_SWEEP:
            begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (proceed)
                begin
                    state_next = S_IDLE;
                    if (has_result)
                    begin
                        out_valid_next = 1'b1;
                    end
                    if (mode_reg == MODE_CLEAR)
                    begin
                        pos_next = '0;
                        if (gen_reg == {GEN_W{1'b1}})
                        begin
                            gen_next   = GEN_W'(1);
                            state_next = S_SWEEP;
                        end
                        else
                        begin
                            gen_next = gen_reg + 1'b1;
                        end
                    end
                    else if (do_bump && (pos_reg != {POSITION_WIDTH{1'b1}}))
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            gen_reg       <= GEN_W'(1);
            pos_reg       <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_reg       <= gen_next;
            pos_reg       <= pos_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_EXEC) && proceed && has_result)
        begin
            position_reg   <= pos_to_out(res_pos);
            found_reg      <= present;
            first_seen_reg <= (mode_reg == MODE_SELF) && !present;
        end
    end

    assign out_valid  = out_valid_reg;
    assign position   = position_reg;
    assign found      = found_reg;
    assign first_seen = first_seen_reg;

    `SIDX_ASSERT_NEXT(a_accept_reads, in_accept, state_reg == S_READ)
    `SIDX_ASSERT_NEXT(a_read_then_exec, state_reg == S_READ, state_reg == S_EXEC)
    `SIDX_ASSERT_NOW(a_store_in_range, mem_we && (state_reg == S_EXEC), inr_reg)
    `SIDX_ASSERT_NOW(a_sweep_gen_one, state_reg == S_SWEEP, gen_reg == GEN_W'(1))
    `SIDX_ASSERT_NOW(a_result_from_exec, $rose(out_valid_reg), $past(state_reg == S_EXEC))

endmodule
